### rtl/core/pace_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pace_pkg: shared types and helpers for the alphanumeric character extractor
// Holds the field widths, the batch of characters that one message word gives,
// and the bit reversal that turns a stream group into a character.
// ----------------------------------------------------------------------------
package pace_pkg;

    localparam int WordBits    = 32;
    localparam int CharBits    = 7;
    localparam int PayloadBits = 20;
    localparam int PayloadLsb  = 11;
    localparam int LeftBits    = 6;
    localparam int MaxChars    = 3;
    localparam int StreamBits  = LeftBits + PayloadBits;

    typedef logic [WordBits-1:0] t_word;
    typedef logic [CharBits-1:0] t_char;
    typedef logic [LeftBits-1:0] t_left_bits;
    typedef logic [2:0]          t_left_cnt;
    typedef logic [1:0]          t_char_cnt;

    // Characters in emission order: chars[0] goes out first.
    typedef struct packed {
        t_char [MaxChars-1:0] chars;
        t_char_cnt            count;
    } t_char_batch;

    // The first stream bit of a group becomes bit 0 of the character.
    function automatic t_char rev7(input t_char v);
        t_char r;
        for (int i = 0; i < CharBits; i++) begin
            r[i] = v[CharBits-1-i];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/pace_word_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pace_word_if: codeword request channel
// Carries one received 32-bit codeword per request with valid/ready.
// ----------------------------------------------------------------------------
interface pace_word_if;
    logic                 valid;
    logic                 ready;
    pace_pkg::t_word      codeword;

    modport source (output valid, output codeword, input ready);
    modport sink   (input valid, input codeword, output ready);
endinterface
`default_nettype wire

### rtl/core/pace_char_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pace_char_if: character request channel
// Carries one decoded character per request with valid/ready.
// ----------------------------------------------------------------------------
interface pace_char_if;
    logic                 valid;
    logic                 ready;
    pace_pkg::t_char      character;
    logic                 last_of_run;

    modport source (output valid, output character, output last_of_run, input ready);
    modport sink   (input valid, input character, input last_of_run, output ready);
endinterface
`default_nettype wire

### rtl/core/pace_unpack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pace_unpack: splits one message word into characters
// Joins the carried bits with the 20 payload bits, cuts 7-bit groups from the
// front and returns the bits that are left for the next message word.
// ----------------------------------------------------------------------------
module pace_unpack (
    input  pace_pkg::t_word       i_codeword,
    input  pace_pkg::t_left_bits  i_left_bits,
    input  pace_pkg::t_left_cnt   i_left_count,
    output pace_pkg::t_char_batch o_batch,
    output pace_pkg::t_left_bits  o_left_bits,
    output pace_pkg::t_left_cnt   o_left_count
);
    import pace_pkg::*;

    t_left_cnt             cnt;
    t_left_cnt             next_cnt;
    logic [StreamBits-1:0] stream;
    logic [StreamBits-1:0] aligned;

    always_comb begin
        cnt = (i_left_count > 3'd6) ? 3'd6 : i_left_count;
        stream = {i_left_bits & ~(6'h3F << cnt),
                  i_codeword[PayloadLsb+PayloadBits-1:PayloadLsb]};
        // Move the oldest valid bit to the top of the stream.
        aligned = stream << (3'd6 - cnt);

        o_batch.chars[0] = rev7(aligned[StreamBits-1  -: CharBits]);
        o_batch.chars[1] = rev7(aligned[StreamBits-8  -: CharBits]);
        o_batch.chars[2] = rev7(aligned[StreamBits-15 -: CharBits]);
        o_batch.count    = (cnt == 3'd0) ? 2'd2 : 2'd3;

        // Twenty bits alone give two characters and six spare bits;
        // any carried bit completes a third character.
        next_cnt     = (cnt == 3'd0) ? 3'd6 : cnt - 3'd1;
        o_left_count = next_cnt;
        o_left_bits  = stream[LeftBits-1:0] & ~(6'h3F << next_cnt);
    end

endmodule
`default_nettype wire

### rtl/core/pace_char_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pace_char_queue: result register for up to three characters
// Loads a whole batch at once and shifts one character out per request.
// ----------------------------------------------------------------------------
module pace_char_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  pace_pkg::t_char_batch  i_batch,
    output logic                   o_can_load,
    pace_char_if.source            o_char
);
    import pace_pkg::*;

    t_char     r_chars [MaxChars];
    t_char_cnt r_left;
    logic      fire;

    assign o_char.valid       = (r_left != 2'd0);
    assign o_char.character   = r_chars[0];
    assign o_char.last_of_run = (r_left == 2'd1);
    assign fire               = o_char.valid && o_char.ready;
    assign o_can_load         = (r_left == 2'd0) || ((r_left == 2'd1) && fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (i_load) begin
            r_left <= i_batch.count;
        end else if (fire) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < MaxChars; i++) begin
                r_chars[i] <= i_batch.chars[i];
            end
        end else if (fire) begin
            r_chars[0] <= r_chars[1];
            r_chars[1] <= r_chars[2];
        end
    end

endmodule
`default_nettype wire

### rtl/core/pocsag_alpha_char_extractor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pocsag_alpha_char_extractor: streaming alphanumeric message decoder
// Turns message codewords into 7-bit characters, carrying spare stream bits
// from one message word to the next. Address and idle words are dropped.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Payload                         Per request
//   i_word    in    codeword[31:0]                  one codeword
//   o_char    out   character[6:0], last_of_run     one character
//
// A message word gives two or three characters, sent one per cycle while
// o_char is ready; the output queue register holds them, so the block takes
// no new word before the last queued character goes. A new word is taken in
// the same cycle that the last queued character is taken, so there is no gap
// between words. Address and idle words are taken whenever the queue can load.
// Reset clears the carried bits and empties the queue. A stall on o_char
// holds the current character and keeps i_word.ready low once it is the last.
// ----------------------------------------------------------------------------
module pocsag_alpha_char_extractor (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pace_word_if.sink   i_word,
    pace_char_if.source o_char
);
    import pace_pkg::*;

    // Stream bits carried between message words, right aligned.
    t_left_bits  r_left_bits;
    t_left_cnt   r_left_count;
    t_left_bits  n_left_bits;
    t_left_cnt   n_left_count;

    t_char_batch batch;
    logic        can_load;
    logic        word_fire;
    logic        load;

    pace_unpack u_unpack (
        .i_codeword   (i_word.codeword),
        .i_left_bits  (r_left_bits),
        .i_left_count (r_left_count),
        .o_batch      (batch),
        .o_left_bits  (n_left_bits),
        .o_left_count (n_left_count)
    );

    // Bit 31 set marks a message word; only those touch the queue or state.
    assign i_word.ready = can_load;
    assign word_fire    = i_word.valid && can_load;
    assign load         = word_fire && i_word.codeword[WordBits-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bits  <= '0;
            r_left_count <= '0;
        end else if (load) begin
            r_left_bits  <= n_left_bits;
            r_left_count <= n_left_count;
        end
    end

    pace_char_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_batch    (batch),
        .o_can_load (can_load),
        .o_char     (o_char)
    );

endmodule
`default_nettype wire
